// ===== rtl/core/slfr_pkg.sv =====
// shared types and constants for the sync/length frame receiver
// used by slfr_step and sync_length_frame_receiver; no dependencies
package slfr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned FLEN_W  = 9;
    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hAA;
    localparam logic [BYTE_W-1:0] MIN_LENGTH = 8'd2;

    // receiver mode, one-hot
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_ARMED = 3'b010,
        MODE_RECV  = 3'b100
    } t_mode;

    // frame tracking state carried between items
    typedef struct packed {
        t_mode             mode;
        logic [BYTE_W-1:0] last_index;
        logic [BYTE_W-1:0] byte_index;
        logic [BYTE_W-1:0] running_sum;
    } t_rx_state;

    // one tagged result item
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              in_frame;
        logic [BYTE_W-1:0] position;
        logic              frame_done;
        logic              checksum_ok;
        logic [FLEN_W-1:0] frame_length;
        logic              length_error;
    } t_result;

endpackage

// ===== rtl/core/slfr_step.sv =====
// per-byte next-state and tagging logic of the frame receiver
// depends on slfr_pkg; purely combinational
module slfr_step (
    input  slfr_pkg::t_rx_state          i_state,
    input  logic [slfr_pkg::BYTE_W-1:0]  i_rx_byte,
    input  logic [slfr_pkg::BYTE_W-1:0]  i_sync_byte,
    output slfr_pkg::t_rx_state          o_state,
    output slfr_pkg::t_result            o_result
);
    import slfr_pkg::*;

    logic              is_sync;
    logic [BYTE_W-1:0] next_idx;
    logic [BYTE_W-1:0] expect_chk;

    assign is_sync    = (i_rx_byte == i_sync_byte);
    assign next_idx   = i_state.byte_index + BYTE_W'(1);
    assign expect_chk = BYTE_W'(0) - i_state.running_sum;

    // mode transitions and result tags
    always_comb begin
        o_state               = i_state;
        o_result              = '0;
        o_result.data_byte    = i_rx_byte;
        unique case (i_state.mode)
            MODE_ARMED: begin
                o_result.in_frame = 1'b1;
                o_result.position = BYTE_W'(1);
                if (i_rx_byte < MIN_LENGTH) begin
                    o_result.length_error = 1'b1;
                    o_state = '{MODE_IDLE, '0, '0, '0};
                end else begin
                    o_state = '{MODE_RECV, i_rx_byte, BYTE_W'(1), i_rx_byte};
                end
            end
            MODE_RECV: begin
                if (next_idx == i_state.last_index) begin
                    // checksum byte closes the frame
                    o_result.in_frame     = 1'b1;
                    o_result.position     = next_idx;
                    o_result.frame_done   = 1'b1;
                    o_result.checksum_ok  = (expect_chk == i_rx_byte);
                    o_result.frame_length = {1'b0, i_state.last_index} + FLEN_W'(1);
                    o_state = '{(is_sync ? MODE_ARMED : MODE_IDLE), '0, '0, '0};
                end else if (is_sync) begin
                    // sync mid-frame abandons and re-arms
                    o_state = '{MODE_ARMED, '0, '0, '0};
                end else begin
                    o_result.in_frame    = 1'b1;
                    o_result.position    = next_idx;
                    o_state.byte_index   = next_idx;
                    o_state.running_sum  = i_state.running_sum + i_rx_byte;
                end
            end
            default: begin
                // idle, and any stray code behaves as idle
                o_state.mode = is_sync ? MODE_ARMED : MODE_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/sync_length_frame_receiver.sv =====
// sync/length framed byte receiver with two's-complement checksum check
// result registered, valid in the cycle after input accept; one item per cycle while the output is not stalled
// a new item is taken whenever the result register is empty or being drained
// synchronous active-low reset: idle (not armed), sync byte 0xAA, no result pending
// depends on slfr_pkg and slfr_step
module sync_length_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write: sync byte value
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] data_byte, [15:8] position,
                                        // [24:16] frame_length, [31:25] zero
    output logic        m_axis_tlast,   // frame_done
    output logic [2:0]  m_axis_tuser    // [0] in_frame, [1] checksum_ok, [2] length_error
);
    import slfr_pkg::*;

    logic [BYTE_W-1:0] r_sync_byte;
    t_rx_state         r_state;
    t_rx_state         n_state;
    t_result           r_res;
    t_result           n_res;
    logic              r_out_valid;
    logic              in_accept;

    // configuration register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte <= SYNC_RESET;
        end else if (i_cfg_valid) begin
            r_sync_byte <= i_cfg_data;
        end
    end

    // input handshake, output register parts the two sides
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    slfr_step u_step (
        .i_state     (r_state),
        .i_rx_byte   (s_axis_tdata),
        .i_sync_byte (r_sync_byte),
        .o_state     (n_state),
        .o_result    (n_res)
    );

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{MODE_IDLE, '0, '0, '0};
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_res <= n_res;
        end
    end

    // output packing
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_res.frame_length, r_res.position, r_res.data_byte};
    assign m_axis_tlast  = r_res.frame_done;
    assign m_axis_tuser  = {r_res.length_error, r_res.checksum_ok, r_res.in_frame};

    // outside a frame the counters and sum stay cleared
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode != MODE_RECV) |->
        (r_state.byte_index == '0 && r_state.last_index == '0 && r_state.running_sum == '0))
        else $error("frame counters not cleared outside a frame");

    // while receiving, the index stays below the checksum index of a valid length
    a_recv_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == MODE_RECV) |->
        (r_state.last_index >= MIN_LENGTH && r_state.byte_index < r_state.last_index))
        else $error("receive index out of range");

    // a completed frame result is tagged in-frame and carries no length error
    a_done_tags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.frame_done) |->
        (r_res.in_frame && !r_res.length_error && r_res.frame_length > FLEN_W'(2)))
        else $error("inconsistent frame completion tags");

    // a length error follows only from an armed receiver
    a_lerr_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && n_res.length_error) |-> (r_state.mode == MODE_ARMED))
        else $error("length error outside a length byte");

endmodule
